// File: sv/cbq_pkg.sv
// shared types, constants and helper functions for the circular byte queue
// no dependencies; used by every other file of the block
`default_nettype none

package cbq_pkg;

   localparam int CAPACITY = 7;
   localparam int SLOTS    = CAPACITY + 1;
   localparam int PTR_W    = $clog2(SLOTS);
   localparam int COUNT_W  = 3;
   localparam int BYTE_W   = 8;

   typedef logic [PTR_W-1:0]   ptr_type;
   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef enum logic [2:0] {
      FUNC_ENQ   = 3'd0,
      FUNC_DEQ   = 3'd1,
      FUNC_REPL  = 3'd2,
      FUNC_QUERY = 3'd3,
      FUNC_CLEAR = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_HEAD,
      S_FIN
   } state_type;

   // one access cycle of the slot memory
   typedef struct packed {
      logic     wr_en;
      ptr_type  wr_addr;
      byte_type wr_data;
      logic     rd_en;
      ptr_type  rd_addr;
   } mem_req_type;

   function automatic ptr_type next_slot(ptr_type p);
      return (p == ptr_type'(SLOTS - 1)) ? '0 : p + ptr_type'(1);
   endfunction

   function automatic count_type ptr_count(ptr_type front, ptr_type rear);
      logic [PTR_W:0] diff;
      diff = {1'b0, rear} - {1'b0, front};
      if (rear < front) begin
         diff = diff + (PTR_W+1)'(SLOTS);
      end
      return count_type'(diff);
   endfunction

endpackage

`default_nettype wire

// File: sv/cbq_if.sv
// valid/ready channel interfaces for the request and response sides
// depends on cbq_pkg for payload types
`default_nettype none

interface cbq_req_if;
   logic            valid;
   logic            ready;
   logic [2:0]      func;
   cbq_pkg::byte_type item_value;

   modport source (output valid, output func, output item_value, input ready);
   modport sink   (input valid, input func, input item_value, output ready);
endinterface

interface cbq_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   cbq_pkg::byte_type  out_byte;
   logic               found;
   cbq_pkg::byte_type  head_byte;
   cbq_pkg::count_type count;
   logic               is_full_flag;
   logic               is_empty_flag;

   modport source (output valid, output status, output out_byte, output found,
                   output head_byte, output count, output is_full_flag,
                   output is_empty_flag, input ready);
   modport sink   (input valid, input status, input out_byte, input found,
                   input head_byte, input count, input is_full_flag,
                   input is_empty_flag, output ready);
endinterface

`default_nettype wire

// File: sv/cbq_mem.sv
// slot store: one write port and one read port with registered read data
// depends on cbq_pkg
`default_nettype none

module cbq_mem (
   input  wire logic                 clock,
   input  wire cbq_pkg::mem_req_type mem_req,
   output cbq_pkg::byte_type         rd_data
);

   cbq_pkg::byte_type slot_mem_ff [cbq_pkg::SLOTS];
   cbq_pkg::byte_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         slot_mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      // read data holds until the next read
      if (mem_req.rd_en) begin
         rd_data_ff <= slot_mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/cbq_ctrl.sv
// sequencer for the queue: pointers, operation decode, search and response register
// depends on cbq_pkg and cbq_if; drives the slot memory through mem_req
`default_nettype none

module cbq_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   cbq_req_if.sink                    req_if,
   cbq_rsp_if.source                  rsp_if,
   output cbq_pkg::mem_req_type       mem_req,
   input  wire cbq_pkg::byte_type     rd_data
);

   cbq_pkg::state_type  state_ff, state_in;
   cbq_pkg::func_type   func_ff, func_in;
   cbq_pkg::byte_type   val_ff, val_in;
   cbq_pkg::ptr_type    front_ff, front_in;
   cbq_pkg::ptr_type    rear_ff, rear_in;
   cbq_pkg::status_type status_ff, status_in;
   cbq_pkg::byte_type   out_byte_ff, out_byte_in;
   logic                found_ff, found_in;
   logic                deq_take_ff, deq_take_in;
   cbq_pkg::ptr_type    scan_addr_ff, scan_addr_in;
   cbq_pkg::count_type  issue_left_ff, issue_left_in;
   cbq_pkg::count_type  cmp_left_ff, cmp_left_in;
   logic                pend_ff, pend_in;

   logic                rsp_valid_ff, rsp_valid_in;
   cbq_pkg::status_type rsp_status_ff;
   cbq_pkg::byte_type   rsp_out_byte_ff;
   logic                rsp_found_ff;
   cbq_pkg::byte_type   rsp_head_ff;
   cbq_pkg::count_type  rsp_count_ff;
   logic                rsp_full_ff;
   logic                rsp_empty_ff;

   logic req_xfer;
   logic q_empty;
   logic q_full;
   logic scan_hit;
   logic scan_last;
   logic rsp_load;

   assign q_empty   = (front_ff == rear_ff);
   assign q_full    = (cbq_pkg::next_slot(rear_ff) == front_ff);
   assign req_xfer  = req_if.valid && (state_ff == cbq_pkg::S_IDLE);
   assign scan_hit  = pend_ff && (rd_data == val_ff);
   assign scan_last = pend_ff && (cmp_left_ff == cbq_pkg::count_type'(1));
   assign rsp_load  = (state_ff == cbq_pkg::S_FIN) && (!rsp_valid_ff || rsp_if.ready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cbq_pkg::S_IDLE: begin
            if (req_xfer) begin
               state_in = cbq_pkg::S_EXEC;
            end
         end
         cbq_pkg::S_EXEC: begin
            if (func_ff == cbq_pkg::FUNC_QUERY && !q_empty) begin
               state_in = cbq_pkg::S_SCAN;
            end else begin
               state_in = cbq_pkg::S_HEAD;
            end
         end
         cbq_pkg::S_SCAN: begin
            if (scan_hit || scan_last) begin
               state_in = cbq_pkg::S_HEAD;
            end
         end
         cbq_pkg::S_HEAD: state_in = cbq_pkg::S_FIN;
         cbq_pkg::S_FIN: begin
            if (rsp_load) begin
               state_in = cbq_pkg::S_IDLE;
            end
         end
         default: state_in = cbq_pkg::S_IDLE;
      endcase
   end

   // datapath and memory access
   always_comb begin
      func_in       = func_ff;
      val_in        = val_ff;
      front_in      = front_ff;
      rear_in       = rear_ff;
      status_in     = status_ff;
      out_byte_in   = out_byte_ff;
      found_in      = found_ff;
      deq_take_in   = deq_take_ff;
      scan_addr_in  = scan_addr_ff;
      issue_left_in = issue_left_ff;
      cmp_left_in   = cmp_left_ff;
      pend_in       = 1'b0;
      mem_req       = '0;
      mem_req.wr_data = val_ff;

      unique case (state_ff)
         cbq_pkg::S_IDLE: begin
            if (req_xfer) begin
               func_in = cbq_pkg::func_type'(req_if.func);
               val_in  = req_if.item_value;
            end
         end
         cbq_pkg::S_EXEC: begin
            status_in   = cbq_pkg::STAT_OK;
            out_byte_in = '0;
            found_in    = 1'b0;
            deq_take_in = 1'b0;
            unique case (func_ff)
               cbq_pkg::FUNC_ENQ: begin
                  if (q_full) begin
                     status_in = cbq_pkg::STAT_FULL;
                  end else begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = cbq_pkg::next_slot(rear_ff);
                     rear_in         = cbq_pkg::next_slot(rear_ff);
                  end
               end
               cbq_pkg::FUNC_DEQ: begin
                  if (q_empty) begin
                     status_in = cbq_pkg::STAT_EMPTY;
                  end else begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = cbq_pkg::next_slot(front_ff);
                     front_in        = cbq_pkg::next_slot(front_ff);
                     deq_take_in     = 1'b1;
                  end
               end
               cbq_pkg::FUNC_REPL: begin
                  if (q_empty) begin
                     status_in = cbq_pkg::STAT_EMPTY;
                  end else begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = rear_ff;
                  end
               end
               cbq_pkg::FUNC_QUERY: begin
                  if (q_empty) begin
                     status_in = cbq_pkg::STAT_EMPTY;
                  end else begin
                     scan_addr_in  = cbq_pkg::next_slot(front_ff);
                     issue_left_in = cbq_pkg::ptr_count(front_ff, rear_ff);
                     cmp_left_in   = cbq_pkg::ptr_count(front_ff, rear_ff);
                  end
               end
               cbq_pkg::FUNC_CLEAR: begin
                  if (q_empty) begin
                     status_in = cbq_pkg::STAT_EMPTY;
                  end else begin
                     front_in = rear_ff;
                  end
               end
               default: begin
               end
            endcase
         end
         cbq_pkg::S_SCAN: begin
            // reads issue one per cycle; each compare happens in the cycle after its read
            if (issue_left_ff != '0) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = scan_addr_ff;
               scan_addr_in    = cbq_pkg::next_slot(scan_addr_ff);
               issue_left_in   = issue_left_ff - cbq_pkg::count_type'(1);
               pend_in         = 1'b1;
            end
            if (pend_ff) begin
               cmp_left_in = cmp_left_ff - cbq_pkg::count_type'(1);
            end
            if (scan_hit) begin
               found_in = 1'b1;
            end
         end
         cbq_pkg::S_HEAD: begin
            if (deq_take_ff) begin
               out_byte_in = rd_data;
            end
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = cbq_pkg::next_slot(front_ff);
         end
         cbq_pkg::S_FIN: begin
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cbq_pkg::S_IDLE;
         front_ff     <= '0;
         rear_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         deq_take_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         rear_ff      <= rear_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         deq_take_ff  <= deq_take_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      val_ff        <= val_in;
      status_ff     <= status_in;
      out_byte_ff   <= out_byte_in;
      found_ff      <= found_in;
      scan_addr_ff  <= scan_addr_in;
      issue_left_ff <= issue_left_in;
      cmp_left_ff   <= cmp_left_in;
      if (rsp_load) begin
         rsp_status_ff   <= status_ff;
         rsp_out_byte_ff <= out_byte_ff;
         rsp_found_ff    <= found_ff;
         rsp_head_ff     <= q_empty ? '0 : rd_data;
         rsp_count_ff    <= cbq_pkg::ptr_count(front_ff, rear_ff);
         rsp_full_ff     <= q_full;
         rsp_empty_ff    <= q_empty;
      end
   end

   assign req_if.ready         = (state_ff == cbq_pkg::S_IDLE);
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = rsp_status_ff;
   assign rsp_if.out_byte      = rsp_out_byte_ff;
   assign rsp_if.found         = rsp_found_ff;
   assign rsp_if.head_byte     = rsp_head_ff;
   assign rsp_if.count         = rsp_count_ff;
   assign rsp_if.is_full_flag  = rsp_full_ff;
   assign rsp_if.is_empty_flag = rsp_empty_ff;

endmodule

`default_nettype wire

// File: sv/circular_byte_queue_top.sv
// Circular byte queue of 7 bytes (8 slots, one kept spare) with enqueue, dequeue,
// replace-newest, member query and clear. One request is taken at a time; each
// gives exactly one response carrying the status, the dequeued byte, the search
// result and the head byte, count and full/empty flags after the operation. A
// request passes through the execute, head-read and finish states; a member
// query on a non-empty queue also passes through a search state, which reads
// the stored slots one per cycle through the single read port of the slot
// memory and ends early when the byte is found. A new request is taken while a
// finished response still waits in the output register. No clearing pass is
// needed after reset.
// depends on cbq_pkg, cbq_if, cbq_mem and cbq_ctrl
`default_nettype none

module circular_byte_queue_top (
   input  wire logic clock,
   input  wire logic reset,
   cbq_req_if.sink   req_if,
   cbq_rsp_if.source rsp_if
);

   cbq_pkg::mem_req_type mem_req;
   cbq_pkg::byte_type    rd_data;

   cbq_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   cbq_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> !(rsp_if.is_full_flag && rsp_if.is_empty_flag))
      else $error("full and empty flags both set");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.is_empty_flag == (rsp_if.count == '0)))
      else $error("empty flag disagrees with count");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.is_full_flag
         |-> (rsp_if.count == cbq_pkg::count_type'(cbq_pkg::CAPACITY)))
      else $error("full flag with count below capacity");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && (rsp_if.status == cbq_pkg::STAT_FULL) |-> rsp_if.is_full_flag)
      else $error("enqueue dropped while queue not full");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.found
         |-> (rsp_if.status == cbq_pkg::STAT_OK) && !rsp_if.is_empty_flag)
      else $error("search hit reported on empty queue");

endmodule

`default_nettype wire
